FILE: sv/nvme_io_queue_pair_engine_top_assert.svh
// Assertion macros for the NVMe queue pair engine.
// Included by the RTL modules that carry concurrent assertions; no other dependencies.
`ifndef NVME_IO_QUEUE_PAIR_ENGINE_TOP_ASSERT_SVH
`define NVME_IO_QUEUE_PAIR_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define NVMEQP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("nvmeqp assertion failed");
`define NVMEQP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `NVMEQP_ASSERT(lbl, clk, rstn, !(cond))
`else
`define NVMEQP_ASSERT(lbl, clk, rstn, prop)
`define NVMEQP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: sv/nvmeqp_pkg.sv
// Shared types, codes and constants of the NVMe queue pair engine.
// Used by every module of the block; depends on nothing else.
package nvmeqp_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned SlotW      = $clog2(QueueDepth);
  localparam int unsigned SlotOutW   = 3;
  localparam int unsigned PageOffW   = 12;
  localparam int unsigned PageBytes  = 4096;
  localparam int unsigned BlockShift = 9;
  localparam int unsigned CountW     = 17;
  localparam int unsigned SpanW      = CountW + BlockShift + 1;
  localparam int unsigned DbW        = 19;
  localparam int unsigned DbBase     = 'h1000;
  localparam int unsigned SqDbSlot   = 2;
  localparam int unsigned CqDbSlot   = 3;
  localparam int unsigned PollW      = 22;
  localparam int unsigned PollLimitRst = 3000000;
  localparam int unsigned InDataW    = 168;
  localparam int unsigned OutDataW   = 304;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [7:0] OpRead  = 8'h02;
  localparam logic [7:0] OpWrite = 8'h01;

  typedef enum logic [1:0] {
    ReqRead  = 2'd0,
    ReqWrite = 2'd1,
    ReqPoll  = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    KindSubmitted = 3'd0,
    KindRejected  = 3'd1,
    KindDoneOk    = 3'd2,
    KindDoneErr   = 3'd3,
    KindPending   = 3'd4,
    KindTimeout   = 3'd5
  } result_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEnabled   = 8'd0,
    CfgNamespace = 8'd1,
    CfgStride    = 8'd2,
    CfgPollLimit = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             enabled;
    logic [31:0]      namespace_id;
    logic [3:0]       doorbell_stride;
    logic [PollW-1:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [63:0]       start_block;
    logic [CountW-1:0] block_count;
    logic [63:0]       buffer_address;
    logic [15:0]       completion_word;
  } in_item_t;

  typedef struct packed {
    result_kind_e        result_kind;
    logic [7:0]          opcode;
    logic [15:0]         command_tag;
    logic [31:0]         nsid_out;
    logic [63:0]         prp_first;
    logic [63:0]         prp_second;
    logic [63:0]         slba_out;
    logic [15:0]         blocks_minus_one;
    logic [SlotOutW-1:0] slot_index;
    logic [DbW-1:0]      doorbell_offset;
    logic [SlotOutW-1:0] doorbell_value;
    logic [14:0]         status_code;
  } res_item_t;

endpackage

FILE: sv/nvmeqp_cfg.sv
// Configuration register file of the NVMe queue pair engine.
// Depends on nvmeqp_pkg for the register indexes and the configuration struct.
module nvmeqp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nvmeqp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nvmeqp_pkg::CfgDataW-1:0] cfg_data_i,
  output nvmeqp_pkg::cfg_t                cfg_o
);
  import nvmeqp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgEnabled:   cfg_d.enabled         = cfg_data_i[0];
        CfgNamespace: cfg_d.namespace_id    = cfg_data_i;
        CfgStride:    cfg_d.doorbell_stride = cfg_data_i[3:0];
        CfgPollLimit: cfg_d.poll_limit      = cfg_data_i[PollW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled         <= 1'b0;
      cfg_q.namespace_id    <= 32'd1;
      cfg_q.doorbell_stride <= 4'd0;
      cfg_q.poll_limit      <= PollW'(PollLimitRst);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/nvmeqp_core.sv
// Queue state and result logic of the NVMe queue pair engine.
// Depends on nvmeqp_pkg and the assertion macro header.
`include "nvme_io_queue_pair_engine_top_assert.svh"

module nvmeqp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nvmeqp_pkg::cfg_t      cfg_i,
  input  logic                  fire_i,
  input  nvmeqp_pkg::in_item_t  item_i,
  output nvmeqp_pkg::res_item_t res_o
);
  import nvmeqp_pkg::*;

  logic [SlotW-1:0] tail_q, tail_d;
  logic [SlotW-1:0] head_q, head_d;
  logic             phase_q, phase_d;
  logic [15:0]      tag_q, tag_d;
  logic             busy_q, busy_d;
  logic [PollW-1:0] poll_cnt_q, poll_cnt_d;

  logic [SpanW-1:0] span;
  logic [PollW-1:0] poll_inc;
  logic [14:0]      status;
  logic [DbW-1:0]   stride_sq;
  logic [DbW-1:0]   stride_cq;

  always_comb begin
    span      = SpanW'(item_i.buffer_address[PageOffW-1:0])
              + SpanW'({item_i.block_count, {BlockShift{1'b0}}});
    poll_inc  = poll_cnt_q + PollW'(1);
    status    = item_i.completion_word[15:1];
    stride_sq = DbW'(SqDbSlot * 4) << cfg_i.doorbell_stride;
    stride_cq = DbW'(CqDbSlot * 4) << cfg_i.doorbell_stride;

    res_o             = '0;
    res_o.result_kind = KindRejected;
    tail_d            = tail_q;
    head_d            = head_q;
    phase_d           = phase_q;
    tag_d             = tag_q;
    busy_d            = busy_q;
    poll_cnt_d        = poll_cnt_q;

    case (item_i.req_type)
      ReqRead, ReqWrite: begin
        if (cfg_i.enabled && (item_i.block_count != '0) && !busy_q) begin
          tag_d                  = tag_q + 16'd1;
          tail_d                 = (tail_q == SlotW'(QueueDepth - 1)) ? '0
                                                                      : tail_q + SlotW'(1);
          res_o.result_kind      = KindSubmitted;
          res_o.opcode           = (item_i.req_type == ReqRead) ? OpRead : OpWrite;
          res_o.command_tag      = tag_d;
          res_o.nsid_out         = cfg_i.namespace_id;
          res_o.prp_first        = item_i.buffer_address;
          if (span > SpanW'(PageBytes)) begin
            res_o.prp_second = {item_i.buffer_address[63:PageOffW] + (64 - PageOffW)'(1),
                                {PageOffW{1'b0}}};
          end
          res_o.slba_out         = item_i.start_block;
          res_o.blocks_minus_one = 16'(item_i.block_count - CountW'(1));
          res_o.slot_index       = SlotOutW'(tail_q);
          res_o.doorbell_offset  = DbW'(DbBase) + stride_sq;
          res_o.doorbell_value   = SlotOutW'(tail_d);
          busy_d                 = 1'b1;
          poll_cnt_d             = '0;
        end
      end
      ReqPoll: begin
        if (busy_q) begin
          res_o.command_tag = tag_q;
          res_o.slot_index  = SlotOutW'(head_q);
          if (item_i.completion_word[0] == phase_q) begin
            head_d                = (head_q == SlotW'(QueueDepth - 1)) ? '0
                                                                       : head_q + SlotW'(1);
            phase_d               = (head_d == '0) ? ~phase_q : phase_q;
            res_o.result_kind     = (status == '0) ? KindDoneOk : KindDoneErr;
            res_o.doorbell_offset = DbW'(DbBase) + stride_cq;
            res_o.doorbell_value  = SlotOutW'(head_d);
            res_o.status_code     = status;
            busy_d                = 1'b0;
            poll_cnt_d            = '0;
          end else if (poll_inc >= cfg_i.poll_limit) begin
            res_o.result_kind = KindTimeout;
            busy_d            = 1'b0;
            poll_cnt_d        = '0;
          end else begin
            res_o.result_kind = KindPending;
            poll_cnt_d        = poll_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q     <= '0;
      head_q     <= '0;
      phase_q    <= 1'b1;
      tag_q      <= '0;
      busy_q     <= 1'b0;
      poll_cnt_q <= '0;
    end else if (fire_i) begin
      tail_q     <= tail_d;
      head_q     <= head_d;
      phase_q    <= phase_d;
      tag_q      <= tag_d;
      busy_q     <= busy_d;
      poll_cnt_q <= poll_cnt_d;
    end
  end

  `NVMEQP_ASSERT(a_submit_sets_busy, clk_i, rst_ni,
                 (fire_i && res_o.result_kind == KindSubmitted) |=> busy_q)
  `NVMEQP_ASSERT(a_idle_poll_rejected, clk_i, rst_ni,
                 (item_i.req_type == ReqPoll && !busy_q) |-> (res_o.result_kind == KindRejected))
  `NVMEQP_ASSERT(a_timeout_clears, clk_i, rst_ni,
                 (fire_i && res_o.result_kind == KindTimeout) |=> (!busy_q && poll_cnt_q == '0))
  `NVMEQP_ASSERT_NEVER(a_busy_no_submit, clk_i, rst_ni,
                       busy_q && res_o.result_kind == KindSubmitted)

endmodule

FILE: sv/nvme_io_queue_pair_engine_top.sv
// Top level of the NVMe queue pair engine: stream ports, input and result registers.
// Depends on nvmeqp_pkg, nvmeqp_cfg and nvmeqp_core.
//
// The engine takes one request or poll per cycle while the result stream is not stalled
// and returns exactly one result for each, held first in the input register and then in
// the result register; the queue state is updated as an item moves between the two.
// Backpressure on the result stream holds the result register, and the input register
// still accepts one more item behind it. Configuration writes are accepted every cycle
// and are meant to be made only while no item is in flight.
module nvme_io_queue_pair_engine_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nvmeqp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nvmeqp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_block, block_count, buffer_address, completion_word, zero pad
  input  logic [nvmeqp_pkg::InDataW-1:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // opcode, command_tag, nsid_out, prp_first, prp_second, slba_out, blocks_minus_one,
  // slot_index, doorbell_offset, doorbell_value, status_code
  output logic [nvmeqp_pkg::OutDataW-1:0] m_axis_tdata,
  // result_kind
  output logic [2:0]                      m_axis_tuser
);
  import nvmeqp_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  res_item_t res;
  res_item_t out_q;
  logic      out_vld_q, out_vld_d;
  logic      s_fire;
  logic      adv;

  nvmeqp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  nvmeqp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (adv),
    .item_i (in_q),
    .res_o  (res)
  );

  always_comb begin
    adv           = in_vld_q && (!out_vld_q || m_axis_tready);
    s_axis_tready = !in_vld_q || adv;
    s_fire        = s_axis_tvalid && s_axis_tready;
    in_vld_d      = s_fire ? 1'b1 : (adv ? 1'b0 : in_vld_q);
    out_vld_d     = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q.req_type        <= s_axis_tuser;
      in_q.start_block     <= s_axis_tdata[63:0];
      in_q.block_count     <= s_axis_tdata[80:64];
      in_q.buffer_address  <= s_axis_tdata[144:81];
      in_q.completion_word <= s_axis_tdata[160:145];
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.result_kind;
  assign m_axis_tdata  = {out_q.status_code, out_q.doorbell_value, out_q.doorbell_offset,
                          out_q.slot_index, out_q.blocks_minus_one, out_q.slba_out,
                          out_q.prp_second, out_q.prp_first, out_q.nsid_out,
                          out_q.command_tag, out_q.opcode};

endmodule

FILE: tb/sv/tb_nvme_io_queue_pair_engine_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for nvme_io_queue_pair_engine_top: a queue-fed stream driver,
// a result monitor and a queue pair predictor that runs on every accepted input transfer.
// Depends on nvmeqp_pkg and the RTL of the engine.
module tb_nvme_io_queue_pair_engine_top;
  import nvmeqp_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 8;

  typedef struct {
    in_item_t item;
    bit       set_phase;
    bit       phase_match;
  } host_item_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;
  logic [1:0]          s_axis_tuser   = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [2:0]          m_axis_tuser;

  host_item_t  host_items_q[$];
  res_item_t   expected_results_q[$];
  host_item_t  next_item;
  in_item_t    inflight_item;
  res_item_t   seen_result;
  res_item_t   want_result;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned queued_count   = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;

  cfg_t             ctl;
  logic [2:0]       sq_tail;
  logic [2:0]       cq_head;
  logic             cq_phase;
  logic [15:0]      cmd_tag;
  logic             cmd_busy;
  logic [PollW-1:0] miss_polls;

  nvme_io_queue_pair_engine_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [DbW-1:0] doorbell_at(int unsigned slot);
    return DbW'(DbBase + slot * (32'd4 << ctl.doorbell_stride));
  endfunction

  function automatic res_item_t queue_pair_step(in_item_t it);
    res_item_t   r;
    int unsigned span;
    logic [14:0] sc;
    r = '0;
    r.result_kind = KindRejected;
    if (it.req_type == ReqRead || it.req_type == ReqWrite) begin
      if (!ctl.enabled || it.block_count == '0 || cmd_busy) return r;
      cmd_tag = cmd_tag + 16'd1;
      span = 32'(it.buffer_address[PageOffW-1:0]) + (32'(it.block_count) << BlockShift);
      r.result_kind = KindSubmitted;
      r.opcode = (it.req_type == ReqRead) ? OpRead : OpWrite;
      r.command_tag = cmd_tag;
      r.nsid_out = ctl.namespace_id;
      r.prp_first = it.buffer_address;
      if (span > PageBytes) begin
        r.prp_second = {it.buffer_address[63:PageOffW], 12'h000} + 64'(PageBytes);
      end
      r.slba_out = it.start_block;
      r.blocks_minus_one = 16'(it.block_count - 1'b1);
      r.slot_index = sq_tail;
      sq_tail = sq_tail + 3'd1;
      r.doorbell_offset = doorbell_at(SqDbSlot);
      r.doorbell_value = sq_tail;
      cmd_busy = 1'b1;
      miss_polls = '0;
    end else if (it.req_type == ReqPoll && cmd_busy) begin
      r.command_tag = cmd_tag;
      r.slot_index = cq_head;
      if (it.completion_word[0] == cq_phase) begin
        sc = it.completion_word[15:1];
        cq_head = cq_head + 3'd1;
        if (cq_head == 3'd0) cq_phase = ~cq_phase;
        r.result_kind = (sc == '0) ? KindDoneOk : KindDoneErr;
        r.doorbell_offset = doorbell_at(CqDbSlot);
        r.doorbell_value = cq_head;
        r.status_code = sc;
        cmd_busy = 1'b0;
        miss_polls = '0;
      end else begin
        miss_polls = miss_polls + 1'b1;
        if (miss_polls >= ctl.poll_limit) begin
          r.result_kind = KindTimeout;
          cmd_busy = 1'b0;
          miss_polls = '0;
        end else begin
          r.result_kind = KindPending;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results_q.push_back(queue_pair_step(inflight_item));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (host_items_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = host_items_q.pop_front();
          if (next_item.set_phase) begin
            next_item.item.completion_word[0] = next_item.phase_match ? cq_phase : ~cq_phase;
          end
          inflight_item = next_item.item;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= inflight_item.req_type;
          s_axis_tdata  <= {7'b0, inflight_item.completion_word, inflight_item.buffer_address,
                            inflight_item.block_count, inflight_item.start_block};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 name, results_seen, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_result.result_kind = result_kind_e'(m_axis_tuser);
        {seen_result.status_code, seen_result.doorbell_value, seen_result.doorbell_offset,
         seen_result.slot_index, seen_result.blocks_minus_one, seen_result.slba_out,
         seen_result.prp_second, seen_result.prp_first, seen_result.nsid_out,
         seen_result.command_tag, seen_result.opcode} = m_axis_tdata;
        if (expected_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result %0d: kind %0d", results_seen, m_axis_tuser);
          end
        end else begin
          want_result = expected_results_q.pop_front();
          compare_field("result_kind", want_result.result_kind, seen_result.result_kind);
          compare_field("opcode", want_result.opcode, seen_result.opcode);
          compare_field("command_tag", want_result.command_tag, seen_result.command_tag);
          compare_field("nsid_out", want_result.nsid_out, seen_result.nsid_out);
          compare_field("prp_first", want_result.prp_first, seen_result.prp_first);
          compare_field("prp_second", want_result.prp_second, seen_result.prp_second);
          compare_field("slba_out", want_result.slba_out, seen_result.slba_out);
          compare_field("blocks_minus_one", want_result.blocks_minus_one,
                        seen_result.blocks_minus_one);
          compare_field("slot_index", want_result.slot_index, seen_result.slot_index);
          compare_field("doorbell_offset", want_result.doorbell_offset,
                        seen_result.doorbell_offset);
          compare_field("doorbell_value", want_result.doorbell_value,
                        seen_result.doorbell_value);
          compare_field("status_code", want_result.status_code, seen_result.status_code);
        end
        results_seen++;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgEnabled:   ctl.enabled = value[0];
      CfgNamespace: ctl.namespace_id = value;
      CfgStride:    ctl.doorbell_stride = value[3:0];
      CfgPollLimit: ctl.poll_limit = value[PollW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (host_items_q.size() != 0 || s_axis_tvalid || expected_results_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic queue_item(logic [1:0] kind, logic [63:0] lba, logic [CountW-1:0] count,
                            logic [63:0] addr, logic [15:0] cw, bit set_phase, bit match);
    host_item_t h;
    h.item.req_type        = kind;
    h.item.start_block     = lba;
    h.item.block_count     = count;
    h.item.buffer_address  = addr;
    h.item.completion_word = cw;
    h.set_phase   = set_phase;
    h.phase_match = match;
    host_items_q.push_back(h);
    queued_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CountW-1:0] rand_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return CountW'($urandom_range(1, 8));
    if (pick < 80) return CountW'($urandom_range(1, 65536));
    if (pick < 90) return CountW'($urandom_range(9, 64));
    if (pick < 95) return '0;
    return CountW'($urandom_range(65537, 131071));
  endfunction

  function automatic logic [63:0] rand_buffer();
    logic [63:0] addr;
    addr = rand64();
    if ($urandom_range(0, 99) < 30) addr[11:0] = 12'hFFF - 12'($urandom_range(0, 1023));
    return addr;
  endfunction

  function automatic logic [15:0] rand_status_word();
    logic [15:0] cw;
    cw = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 60) cw[15:1] = '0;
    return cw;
  endfunction

  task automatic add_command_sequence();
    if ($urandom_range(0, 99) < 8) begin
      queue_item(2'($urandom_range(0, 3)), rand64(), rand_count(), rand_buffer(),
                 rand_status_word(), 1'b0, 1'b0);
      return;
    end
    queue_item(2'($urandom_range(0, 1)), rand64(), rand_count(), rand_buffer(),
               rand_status_word(), 1'b0, 1'b0);
    if ($urandom_range(0, 99) < 15) begin
      queue_item(2'($urandom_range(0, 1)), rand64(), rand_count(), rand_buffer(),
                 rand_status_word(), 1'b0, 1'b0);
    end
    repeat ($urandom_range(0, 3)) begin
      queue_item(ReqPoll, rand64(), rand_count(), rand_buffer(), rand_status_word(),
                 1'b1, 1'b0);
    end
    if ($urandom_range(0, 99) < 92) begin
      queue_item(ReqPoll, rand64(), rand_count(), rand_buffer(), rand_status_word(),
                 1'b1, 1'b1);
    end
  endtask

  initial begin
    int unsigned phase_items;
    ctl.enabled         = 1'b0;
    ctl.namespace_id    = 32'd1;
    ctl.doorbell_stride = 4'd0;
    ctl.poll_limit      = PollW'(PollLimitRst);
    sq_tail    = '0;
    cq_head    = '0;
    cq_phase   = 1'b1;
    cmd_tag    = '0;
    cmd_busy   = 1'b0;
    miss_polls = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Requests are refused until the controller is enabled.
    queue_item(ReqRead, 64'd5, 17'd1, 64'h1000, 16'h0, 1'b0, 1'b0);
    wait_drained();
    write_register(CfgEnabled, 32'd1);
    write_register(CfgNamespace, 32'hFFFF_FFFF);
    write_register(CfgStride, 32'd15);
    write_register(CfgPollLimit, 32'd2);
    @(negedge clk_i);
    queue_item(ReqRead, 64'd7, 17'd0, 64'h2000, 16'h0, 1'b0, 1'b0);
    queue_item(ReqPoll, 64'd0, 17'd1, 64'd0, 16'h0001, 1'b0, 1'b0);
    queue_item(2'd3, '1, '1, '1, '1, 1'b0, 1'b0);
    queue_item(ReqRead, '1, 17'd1, 64'hFFFF_FFFF_FFFF_FE00, 16'h0, 1'b0, 1'b0);
    queue_item(ReqWrite, 64'd1, 17'd1, 64'd0, 16'h0, 1'b0, 1'b0);
    queue_item(ReqPoll, '0, '0, '0, 16'hFFFF, 1'b1, 1'b0);
    queue_item(ReqPoll, '0, '0, '0, 16'h0000, 1'b1, 1'b0);
    queue_item(ReqWrite, 64'd0, '1, '1, 16'h0, 1'b0, 1'b0);
    queue_item(ReqPoll, '0, '0, '0, 16'hFFFE, 1'b1, 1'b1);
    queue_item(ReqRead, 64'h8000_0000_0000_0000, 17'd65536, 64'd0, 16'h0, 1'b0, 1'b0);
    queue_item(ReqPoll, '1, '1, '1, 16'h0000, 1'b1, 1'b1);
    queue_item(ReqWrite, 64'd3, 17'd1, 64'h0000_0000_0000_0FFF, 16'h0, 1'b0, 1'b0);
    queue_item(ReqPoll, '0, '0, '0, 16'h0002, 1'b1, 1'b1);
    wait_drained();
    write_register(CfgPollLimit, 32'd0);
    @(negedge clk_i);
    queue_item(ReqWrite, 64'd9, 17'd2, 64'h3000, 16'h0, 1'b0, 1'b0);
    queue_item(ReqPoll, '0, '0, '0, 16'h0000, 1'b1, 1'b0);
    queue_item(ReqRead, 64'd10, 17'd9, 64'h4F00, 16'h0, 1'b0, 1'b0);
    queue_item(ReqPoll, '0, '0, '0, 16'h0000, 1'b1, 1'b1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_register(CfgEnabled, (p == 5) ? 32'd0 : 32'd1);
      case (p)
        0: write_register(CfgNamespace, 32'd0);
        1: write_register(CfgNamespace, 32'hFFFF_FFFF);
        default: write_register(CfgNamespace, $urandom);
      endcase
      case (p)
        0: write_register(CfgStride, 32'd0);
        1: write_register(CfgStride, 32'd15);
        default: write_register(CfgStride, $urandom_range(0, 15));
      endcase
      case (p)
        0, 4: write_register(CfgPollLimit, PollLimitRst);
        1: write_register(CfgPollLimit, 32'd1);
        2: write_register(CfgPollLimit, 32'd0);
        5, 7: write_register(CfgPollLimit, $urandom_range(1, PollLimitRst));
        default: write_register(CfgPollLimit, $urandom_range(2, 8));
      endcase
      @(negedge clk_i);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      phase_items = (p == 5) ? 40 : 250;
      queued_count = 0;
      while (queued_count < phase_items) add_command_sequence();
      wait_drained();
    end

    repeat (4 * DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && expected_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
